// ----- design/gtc_pkg.sv -----
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and constants for the global timer comparator
// Command and register codes, control bit positions, word structs.
// ----------------------------------------------------------------------------
`default_nettype none

package gtc_pkg;

  localparam int unsigned PRESCALE_BITS_DEF = 8;
  localparam int unsigned PRESCALE_SHIFT    = 8;

  localparam int unsigned CTL_TIMER_EN = 0;
  localparam int unsigned CTL_COMP_EN  = 1;
  localparam int unsigned CTL_IRQ_EN   = 2;
  localparam int unsigned CTL_AUTO_INC = 3;
  localparam int unsigned CTL_EN_BITS  = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } gtc_cmd_e;

  typedef enum logic [2:0] {
    REG_CNT_LO  = 3'd0,
    REG_CNT_HI  = 3'd1,
    REG_CONTROL = 3'd2,
    REG_STATUS  = 3'd3,
    REG_CMP_LO  = 3'd4,
    REG_CMP_HI  = 3'd5,
    REG_AUTOINC = 3'd6
  } gtc_reg_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } gtc_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } gtc_out_t;

endpackage

`default_nettype wire

// ----- design/global_timer_comparator_core.sv -----
// ----------------------------------------------------------------------------
// global_timer_comparator_core: 64-bit timer with compare and auto-increment
// Ticks, register reads and register writes enter as words; one result each.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i/in_ready_o  | gtc_in_t  (cmd, index, data)
//   out     | output    | out_valid_o/out_ready_i| gtc_out_t (read_data, irq)
//
// One word per cycle while results are taken; registered at input and output.
// Timer state updates when a word moves from the input register to the result
// register; the 64-bit increment and compare set the cycle time.
// Reset clears all timer state; the timer starts disabled.
// A stalled result holds; the input register still takes one more word.
// ----------------------------------------------------------------------------
`default_nettype none

module global_timer_comparator_core
  import gtc_pkg::*;
#(
  parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire gtc_in_t in_word_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output gtc_out_t     out_word_o
);

  logic     held_valid;
  gtc_in_t  held_word;
  logic     out_free;
  logic     fire;
  gtc_out_t result;

  assign fire = held_valid && out_free;

  gtc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .take_i       (fire),
    .held_valid_o (held_valid),
    .held_word_o  (held_word)
  );

  gtc_timer #(
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (held_word),
    .result_o (result)
  );

  gtc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- design/gtc_in_reg.sv -----
// ----------------------------------------------------------------------------
// gtc_in_reg: input word register
// Holds one accepted word until the timer logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_in_reg
  import gtc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire gtc_in_t in_word_i,
  input  wire logic    take_i,
  output logic         held_valid_o,
  output gtc_in_t      held_word_o
);

  logic    valid_q, valid_d;
  gtc_in_t word_q;

  assign in_ready_o   = !valid_q || take_i;
  assign held_valid_o = valid_q;
  assign held_word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/gtc_timer.sv -----
// ----------------------------------------------------------------------------
// gtc_timer: timer state and register file
// Applies one tick, read or write per cycle while fire_i is high, and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_timer
  import gtc_pkg::*;
#(
  parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire gtc_in_t word_i,
  output gtc_out_t     result_o
);

  logic [63:0]              count_q, count_d;
  logic [63:0]              cmp_q, cmp_d;
  logic [CTL_EN_BITS-1:0]   ctl_q, ctl_d;
  logic [PRESCALE_BITS-1:0] presc_lim_q, presc_lim_d;
  logic [PRESCALE_BITS-1:0] presc_cnt_q, presc_cnt_d;
  logic                     flag_q, flag_d;
  logic [31:0]              incr_q, incr_d;
  logic [63:0]              count_inc;
  logic [31:0]              rd;

  assign count_inc = count_q + 64'd1;

  always_comb begin
    count_d     = count_q;
    cmp_d       = cmp_q;
    ctl_d       = ctl_q;
    presc_lim_d = presc_lim_q;
    presc_cnt_d = presc_cnt_q;
    flag_d      = flag_q;
    incr_d      = incr_q;
    rd          = '0;
    unique case (gtc_cmd_e'(word_i.cmd))
      CMD_TICK: begin
        if (ctl_q[CTL_TIMER_EN]) begin
          if (presc_cnt_q < presc_lim_q) begin
            presc_cnt_d = presc_cnt_q + PRESCALE_BITS'(1);
          end else begin
            presc_cnt_d = '0;
            count_d     = count_inc;
            if (ctl_q[CTL_COMP_EN] && (count_inc >= cmp_q)) begin
              flag_d = 1'b1;
              if (ctl_q[CTL_AUTO_INC]) begin
                cmp_d = cmp_q + {32'd0, incr_q};
              end
            end
          end
        end
      end
      CMD_READ: begin
        unique case (gtc_reg_e'(word_i.reg_index))
          REG_CNT_LO:  rd = count_q[31:0];
          REG_CNT_HI:  rd = count_q[63:32];
          REG_CONTROL: rd = 32'(ctl_q) | (32'(presc_lim_q) << PRESCALE_SHIFT);
          REG_STATUS:  rd = {31'd0, flag_q};
          REG_CMP_LO:  rd = cmp_q[31:0];
          REG_CMP_HI:  rd = cmp_q[63:32];
          REG_AUTOINC: rd = incr_q;
          default:     rd = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (gtc_reg_e'(word_i.reg_index))
          REG_CNT_LO:  count_d[31:0]  = word_i.write_data;
          REG_CNT_HI:  count_d[63:32] = word_i.write_data;
          REG_CONTROL: begin
            ctl_d       = word_i.write_data[CTL_EN_BITS-1:0];
            presc_lim_d = word_i.write_data[PRESCALE_SHIFT +: PRESCALE_BITS];
          end
          REG_STATUS: begin
            if (word_i.write_data[0]) begin
              flag_d = 1'b0;
            end
          end
          REG_CMP_LO:  cmp_d[31:0]  = word_i.write_data;
          REG_CMP_HI:  cmp_d[63:32] = word_i.write_data;
          REG_AUTOINC: incr_d = word_i.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.read_data = rd;
  assign result_o.irq       = flag_d & ctl_d[CTL_IRQ_EN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_q       <= '0;
      ctl_q       <= '0;
      presc_lim_q <= '0;
      presc_cnt_q <= '0;
      flag_q      <= 1'b0;
      incr_q      <= '0;
    end else if (fire_i) begin
      count_q     <= count_d;
      cmp_q       <= cmp_d;
      ctl_q       <= ctl_d;
      presc_lim_q <= presc_lim_d;
      presc_cnt_q <= presc_cnt_d;
      flag_q      <= flag_d;
      incr_q      <= incr_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/gtc_out_reg.sv -----
// ----------------------------------------------------------------------------
// gtc_out_reg: result word register
// Holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_out_reg
  import gtc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire gtc_out_t result_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output gtc_out_t      out_word_o
);

  logic     valid_q;
  gtc_out_t word_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/gtc_checker.sv -----
// ----------------------------------------------------------------------------
// gtc_checker: port-level checks for the timer core
// Output handshake rules, result timing and input readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_checker
  import gtc_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire gtc_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without matching input word");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind global_timer_comparator_core gtc_checker u_gtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
